@@ rtl/quoted_argument_tokenizer_defines.svh @@
// assertion macros for the quoted argument tokenizer
`ifndef QUOTED_ARGUMENT_TOKENIZER_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define QAT_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("qat check failed");

`define QAT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("qat check failed");

`else

`define QAT_ASSERT_IMPL(label, pre, post)

`define QAT_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ rtl/qat_pkg.sv @@
// types and constants shared by the quoted argument tokenizer
`timescale 1ns / 1ps

package qat_pkg;

	localparam int CHAR_W      = 21;
	localparam int STATUS_W    = 2;
	localparam int ARGC_W      = 7;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CHAR_W-1:0] CH_END       = 21'h00000;
	localparam logic [CHAR_W-1:0] CH_QUOTE     = 21'h00022;
	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h0005C;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 21'h00020;
	localparam logic [CHAR_W-1:0] CH_TAB       = 21'h00009;
	localparam logic [CHAR_W-1:0] CH_CR        = 21'h0000D;

	typedef enum logic [2:0] {
		MODE_ARG,
		MODE_SPACE,
		MODE_QUOTED,
		MODE_ESC,
		MODE_QESC,
		MODE_ERROR
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_TOO_LONG,
		ST_TOO_MANY,
		ST_UNMATCHED
	} status_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

@@ rtl/quoted_argument_tokenizer.sv @@
// shell style argument splitter, one character word in, one result word out
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: char_code
// m_       out  m_tvalid/m_tready  m_tdata, m_tuser: char_valid, m_tlast: string_done
//
// one word per cycle sustained while m_tready allows; each word passes the input stage, then the result stage
// the rate is set by the single lexer state update between input and result stage
// arst_n clears lexer mode, counters and both stage valids; no clearing pass
// a stalled result stage holds the input stage, which then drops s_tready
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_defines.svh"

module quoted_argument_tokenizer
	import qat_pkg::*;
#(
	parameter int MAX_TOKEN = 256,
	parameter int MAX_ARGS  = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [20:0] char_code
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] out_char, [21] token_end,
	                                          // [23:22] status, [30:24] arg_count
	output logic                   m_tuser,   // [0] char_valid
	output logic                   m_tlast    // string_done
);

	localparam int TLW = (MAX_TOKEN > 2) ? $clog2(MAX_TOKEN) : 1;
	localparam int CW  = $clog2(MAX_ARGS + 1);
	localparam logic [TLW-1:0] TL_LIM   = TLW'(MAX_TOKEN - 1);
	localparam logic [CW-1:0]  ARGS_LIM = CW'(MAX_ARGS);

	// input stage
	logic              v_s1;
	logic [CHAR_W-1:0] c_s1;

	// result stage
	logic              v_s2;
	logic [CHAR_W-1:0] ch_s2;
	logic              valid_s2;
	logic              tend_s2;
	logic              done_s2;
	status_t           status_s2;
	logic [ARGC_W-1:0] argc_s2;

	// lexer state
	mode_t             mode_q, mode_d;
	logic [TLW-1:0]    tl_q, tl_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	status_t           err_q, err_d;

	logic              adv;
	logic              app_ok;
	logic              fin_ok;
	logic              is_end;
	logic [CHAR_W-1:0] ch_c;
	logic              valid_c;
	logic              tend_c;
	logic              done_c;
	logic [CW+6:0]     cnt_ext;

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	assign app_ok = (tl_q < TL_LIM);
	assign fin_ok = (cnt_q < ARGS_LIM);
	assign is_end = (c_s1 == CH_END);

	always_comb begin
		mode_d  = mode_q;
		tl_d    = tl_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		ch_c    = '0;
		valid_c = 1'b0;
		tend_c  = 1'b0;
		done_c  = 1'b0;
		unique case (mode_q)
			MODE_ARG, MODE_ESC: begin
				if (mode_q == MODE_ESC && !is_end) begin
					if (app_ok) begin
						tl_d    = tl_q + TLW'(1);
						ch_c    = c_s1;
						valid_c = 1'b1;
						mode_d  = MODE_ARG;
					end else begin
						err_d  = ST_TOO_LONG;
						mode_d = MODE_ERROR;
					end
				end else if (is_end) begin
					done_c = 1'b1;
					if (tl_q != '0) begin
						if (fin_ok) begin
							cnt_d  = cnt_q + CW'(1);
							tl_d   = '0;
							tend_c = 1'b1;
						end else begin
							err_d  = ST_TOO_MANY;
							mode_d = MODE_ERROR;
						end
					end
				end else if (c_s1 == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else if (c_s1 == CH_QUOTE) begin
					mode_d = MODE_QUOTED;
				end else if (is_blank(c_s1)) begin
					if (tl_q == '0) begin
						mode_d = MODE_SPACE;
					end else if (fin_ok) begin
						cnt_d  = cnt_q + CW'(1);
						tl_d   = '0;
						tend_c = 1'b1;
						mode_d = MODE_SPACE;
					end else begin
						err_d  = ST_TOO_MANY;
						mode_d = MODE_ERROR;
					end
				end else if (app_ok) begin
					tl_d    = tl_q + TLW'(1);
					ch_c    = c_s1;
					valid_c = 1'b1;
				end else begin
					err_d  = ST_TOO_LONG;
					mode_d = MODE_ERROR;
				end
			end
			MODE_SPACE: begin
				if (is_end) begin
					done_c = 1'b1;
				end else if (is_blank(c_s1)) begin
					mode_d = MODE_SPACE;
				end else if (c_s1 == CH_QUOTE) begin
					mode_d = MODE_QUOTED;
				end else if (c_s1 == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else if (app_ok) begin
					tl_d    = tl_q + TLW'(1);
					ch_c    = c_s1;
					valid_c = 1'b1;
					mode_d  = MODE_ARG;
				end else begin
					err_d  = ST_TOO_LONG;
					mode_d = MODE_ERROR;
				end
			end
			MODE_QUOTED: begin
				if (is_end) begin
					err_d  = ST_UNMATCHED;
					done_c = 1'b1;
				end else if (c_s1 == CH_BACKSLASH) begin
					mode_d = MODE_QESC;
				end else if (c_s1 == CH_QUOTE) begin
					mode_d = MODE_ARG;
				end else if (app_ok) begin
					tl_d    = tl_q + TLW'(1);
					ch_c    = c_s1;
					valid_c = 1'b1;
				end else begin
					err_d  = ST_TOO_LONG;
					mode_d = MODE_ERROR;
				end
			end
			MODE_QESC: begin
				if (is_end) begin
					err_d  = ST_UNMATCHED;
					done_c = 1'b1;
				end else if (app_ok) begin
					tl_d    = tl_q + TLW'(1);
					ch_c    = c_s1;
					valid_c = 1'b1;
					mode_d  = MODE_QUOTED;
				end else begin
					err_d  = ST_TOO_LONG;
					mode_d = MODE_ERROR;
				end
			end
			default: begin
				done_c = is_end;
			end
		endcase
	end

	assign cnt_ext = {7'd0, cnt_d};

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			c_s1 <= s_tdata[CHAR_W-1:0];
		end
	end

	// lexer state, back to start after end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ARG;
			tl_q   <= '0;
			cnt_q  <= '0;
			err_q  <= ST_OK;
		end else if (adv) begin
			if (done_c) begin
				mode_q <= MODE_ARG;
				tl_q   <= '0;
				cnt_q  <= '0;
				err_q  <= ST_OK;
			end else begin
				mode_q <= mode_d;
				tl_q   <= tl_d;
				cnt_q  <= cnt_d;
				err_q  <= err_d;
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2     <= ch_c;
			valid_s2  <= valid_c;
			tend_s2   <= tend_c;
			done_s2   <= done_c;
			status_s2 <= err_d;
			argc_s2   <= cnt_ext[ARGC_W-1:0];
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {1'b0, argc_s2, status_s2, tend_s2, ch_s2};
	assign m_tuser  = valid_s2;
	assign m_tlast  = done_s2;

	`QAT_ASSERT_IMPL(a_append_only_ok, v_s2 && valid_s2, status_s2 == ST_OK)
	`QAT_ASSERT_IMPL(a_append_or_end, v_s2, !(valid_s2 && tend_s2))
	`QAT_ASSERT_IMPL(a_limits, 1'b1, (tl_q <= TL_LIM) && (cnt_q <= ARGS_LIM))
	`QAT_ASSERT_NEXT(a_restart, adv && done_c,
		(mode_q == MODE_ARG) && (tl_q == '0) && (cnt_q == '0) && (err_q == ST_OK))

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the quoted argument tokenizer stream block
`timescale 1ns / 1ps

module tb;
	import qat_pkg::*;

	localparam int TOKEN_CAP   = 256;
	localparam int ARGS_CAP    = 64;
	localparam int ITEM_TARGET = 1550;

	localparam logic [CHAR_W-1:0] CH_LF  = 21'h0000A;
	localparam logic [CHAR_W-1:0] CH_VT  = 21'h0000B;
	localparam logic [CHAR_W-1:0] CH_FF  = 21'h0000C;
	localparam logic [CHAR_W-1:0] CH_TOP = 21'h10FFFF;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              valid;
		logic              tend;
		logic              done;
		status_t           st;
		logic [ARGC_W-1:0] argc;
	} split_result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [20:0] char_code
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [20:0] out_char, [21] token_end,
	                                         // [23:22] status, [30:24] arg_count
	logic                   m_tuser;         // [0] char_valid
	logic                   m_tlast;         // string_done

	logic [CHAR_W-1:0] pending_chars[$];
	split_result_t     want_results[$];
	split_result_t     got_want;

	mode_t   lex_st;
	int      tok_len;
	int      arg_n;
	status_t err_st;

	int err_count  = 0;
	int gap_left   = 0;
	int stall_left = 0;
	bit steady_in  = 1'b0;
	bit steady_out = 1'b0;

	quoted_argument_tokenizer #(
		.MAX_TOKEN(TOKEN_CAP),
		.MAX_ARGS (ARGS_CAP)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit blank_code(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic clear_lexer();
		lex_st  = MODE_ARG;
		tok_len = 0;
		arg_n   = 0;
		err_st  = ST_OK;
	endtask

	task automatic take_char(input logic [CHAR_W-1:0] c, inout split_result_t r, output bit ok);
		if (tok_len + 1 >= TOKEN_CAP) begin
			err_st = ST_TOO_LONG;
			lex_st = MODE_ERROR;
			ok = 1'b0;
		end else begin
			tok_len++;
			r.ch    = c;
			r.valid = 1'b1;
			ok = 1'b1;
		end
	endtask

	task automatic close_arg(inout split_result_t r, output bit ok);
		ok = 1'b1;
		if (tok_len != 0) begin
			if (arg_n >= ARGS_CAP) begin
				err_st = ST_TOO_MANY;
				lex_st = MODE_ERROR;
				ok = 1'b0;
			end else begin
				arg_n++;
				tok_len = 0;
				r.tend = 1'b1;
			end
		end
	endtask

	task automatic split_char(input logic [CHAR_W-1:0] c);
		split_result_t r;
		bit ok;
		r.ch    = '0;
		r.valid = 1'b0;
		r.tend  = 1'b0;
		r.done  = 1'b0;
		r.st    = ST_OK;
		r.argc  = '0;
		case (lex_st)
		MODE_ARG, MODE_ESC: begin
			if (lex_st == MODE_ESC && c != CH_END) begin
				take_char(c, r, ok);
				if (ok)
					lex_st = MODE_ARG;
			end else if (c == CH_END) begin
				close_arg(r, ok);
				r.done = 1'b1;
			end else if (c == CH_BACKSLASH) begin
				lex_st = MODE_ESC;
			end else if (c == CH_QUOTE) begin
				lex_st = MODE_QUOTED;
			end else if (blank_code(c)) begin
				close_arg(r, ok);
				if (ok)
					lex_st = MODE_SPACE;
			end else begin
				take_char(c, r, ok);
			end
		end
		MODE_SPACE: begin
			if (c == CH_END) begin
				r.done = 1'b1;
			end else if (blank_code(c)) begin
			end else if (c == CH_QUOTE) begin
				lex_st = MODE_QUOTED;
			end else if (c == CH_BACKSLASH) begin
				lex_st = MODE_ESC;
			end else begin
				take_char(c, r, ok);
				if (ok)
					lex_st = MODE_ARG;
			end
		end
		MODE_QUOTED: begin
			if (c == CH_END) begin
				err_st = ST_UNMATCHED;
				r.done = 1'b1;
			end else if (c == CH_BACKSLASH) begin
				lex_st = MODE_QESC;
			end else if (c == CH_QUOTE) begin
				lex_st = MODE_ARG;
			end else begin
				take_char(c, r, ok);
			end
		end
		MODE_QESC: begin
			if (c == CH_END) begin
				err_st = ST_UNMATCHED;
				r.done = 1'b1;
			end else begin
				take_char(c, r, ok);
				if (ok)
					lex_st = MODE_QUOTED;
			end
		end
		default: begin
			if (c == CH_END)
				r.done = 1'b1;
		end
		endcase
		r.st   = err_st;
		r.argc = arg_n[ARGC_W-1:0];
		want_results.push_back(r);
		if (r.done)
			clear_lexer();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (err_count < 100)
			$display("tb: mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
	                           input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// stimulus helpers
	task automatic push(input logic [CHAR_W-1:0] c);
		pending_chars.push_back(c);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push(CHAR_W'(s[i]));
	endtask

	function automatic logic [CHAR_W-1:0] blank_char();
		case ($urandom_range(0, 5))
		0: return CH_TAB;
		1: return CH_LF;
		2: return CH_VT;
		3: return CH_FF;
		4: return CH_CR;
		default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] c;
		int p;
		p = $urandom_range(0, 9);
		if (p < 6) begin
			do
				c = CHAR_W'($urandom_range(8'h21, 8'h7E));
			while (c == CH_QUOTE || c == CH_BACKSLASH);
		end else if (p < 9) begin
			do
				c = CHAR_W'($urandom_range(1, CH_TOP));
			while (blank_code(c) || c == CH_QUOTE || c == CH_BACKSLASH);
		end else begin
			case ($urandom_range(0, 4))
			0: c = 21'h000001;
			1: c = 21'h00001F;
			2: c = 21'h0F0000;
			3: c = 21'h0FFFFF;
			default: c = CH_TOP;
			endcase
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] any_char();
		case ($urandom_range(0, 7))
		0: return CH_QUOTE;
		1: return CH_BACKSLASH;
		2, 3: return blank_char();
		default: return plain_char();
		endcase
	endfunction

	task automatic push_arg();
		int segs;
		segs = $urandom_range(1, 3);
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(0, 3))
			0, 1: begin
				repeat ($urandom_range(1, 4))
					push(plain_char());
			end
			2: begin
				push(CH_QUOTE);
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 4) == 0) begin
						push(CH_BACKSLASH);
						push(any_char());
					end else if ($urandom_range(0, 3) == 0) begin
						push(blank_char());
					end else begin
						push(plain_char());
					end
				end
				push(CH_QUOTE);
			end
			default: begin
				push(CH_BACKSLASH);
				push(any_char());
			end
			endcase
		end
	endtask

	task automatic push_args(input int n);
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) push(blank_char());
		for (int i = 0; i < n; i++) begin
			push_arg();
			if (i < n - 1)
				repeat ($urandom_range(1, 3)) push(blank_char());
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) push(blank_char());
	endtask

	task automatic push_long_arg(input int n);
		repeat (n)
			push(plain_char());
		if (n < TOKEN_CAP) begin
			push(blank_char());
			push_arg();
		end else begin
			repeat ($urandom_range(1, 6))
				push(any_char());
		end
		push(CH_END);
	endtask

	task automatic push_many_args(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				push(CH_BACKSLASH);
				push(any_char());
			end else begin
				push(plain_char());
			end
			if (i < n - 1 || $urandom_range(0, 1) == 0)
				push(blank_char());
		end
		push(CH_END);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				split_char(s_tdata[CHAR_W-1:0]);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(IN_TDATA_W-CHAR_W){1'b0}}, pending_chars.pop_front()};
					gap_left = steady_in ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if ($urandom_range(0, 149) == 0)
				steady_in = !steady_in;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (want_results.size() == 0) begin
					report_mismatch("result word with none pending", m_tdata, 0);
				end else begin
					got_want = want_results.pop_front();
					check_field("out_char", m_tdata[CHAR_W-1:0], got_want.ch);
					check_field("char_valid", m_tuser, got_want.valid);
					check_field("token_end", m_tdata[CHAR_W], got_want.tend);
					check_field("string_done", m_tlast, got_want.done);
					check_field("status", m_tdata[CHAR_W+1 +: STATUS_W], got_want.st);
					check_field("arg_count", m_tdata[CHAR_W+3 +: ARGC_W], got_want.argc);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!steady_out && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			if ($urandom_range(0, 149) == 0)
				steady_out = !steady_out;
		end
	end

	initial begin
		int special_n;
		int p;
		special_n = 0;
		clear_lexer();

		// empty quotes, every blank, adjoining quotes, extreme codes
		push_text("\t\"\" a");
		push(CH_LF);
		push(CH_VT);
		push(CH_FF);
		push_text("\"x\"y");
		push(CH_CR);
		push(21'h000001);
		push(CH_TOP);
		push(CH_END);
		// escaped quote and trailing backslash
		push_text("\\\"b\\");
		push(CH_END);
		// unmatched quote, then backslash at end inside quotes
		push_text("\"a");
		push(CH_END);
		push_text("\"\\");
		push(CH_END);
		push(CH_END);

		while (pending_chars.size() < ITEM_TARGET || special_n < 4) begin
			if (special_n < 4 && ($urandom_range(0, 7) == 0 ||
			                      pending_chars.size() >= ITEM_TARGET)) begin
				case (special_n)
				0: push_long_arg(TOKEN_CAP - 1);
				1: push_many_args(ARGS_CAP);
				2: push_long_arg(TOKEN_CAP);
				default: push_many_args(ARGS_CAP + 1);
				endcase
				special_n++;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 70) begin
					push_args($urandom_range(0, 5));
					if ($urandom_range(0, 9) == 0)
						push(CH_BACKSLASH);
				end else if (p < 85) begin
					push_args($urandom_range(0, 3));
					push(CH_QUOTE);
					repeat ($urandom_range(0, 3)) push(plain_char());
					if ($urandom_range(0, 1) == 0)
						push(CH_BACKSLASH);
				end else begin
					repeat ($urandom_range(1, 12)) push(any_char());
				end
				push(CH_END);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() > 0 || s_tvalid)
			@(posedge clk);
		while (want_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
